[src/assert_macros.svh]
// Shared assertion macros, clocked on the block clock, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent check.
`define SCS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication check: when cond holds, prop must hold in the same cycle.
`define SCS_ASSERT_IMPL(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) else $error(msg);

`endif

[src/scs_pkg.sv]
package scs_pkg;

   localparam int DEPTH_DEFAULT = 64;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_FLUSH = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TRIM,
      ST_EMIT,
      ST_DROP,
      ST_SKIP
   } state_type;

   // Register select, taken from paddr[2].
   localparam logic REG_MIN = 1'b0;
   localparam logic REG_MAX = 1'b1;

   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QUERY = 8'h3F;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   function automatic logic is_ws(input logic [7:0] c);
      is_ws = (c inside {[8'h09:8'h0D], 8'h20, 8'h85, 8'hA0});
   endfunction

   function automatic logic is_end(input logic [7:0] c);
      is_end = (c == CH_DOT) || (c == CH_BANG) || (c == CH_QUERY) || (c == CH_LF);
   endfunction

endpackage

[src/scs_ring.sv]
// Character store addressed relative to a moving head (circular buffer).
module scs_ring #(
   parameter int DEPTH = scs_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic [$clog2(DEPTH)-1:0]   head,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_idx,
   input  logic [7:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_idx,
   output logic [7:0]                 rd_data
);
   localparam int AW = $clog2(DEPTH);

   logic [7:0]    mem [DEPTH];
   logic [7:0]    rd_data_ff;
   logic [AW:0]   wr_sum;
   logic [AW:0]   rd_sum;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   always_comb begin
      wr_sum = {1'b0, head} + {1'b0, wr_idx};
      rd_sum = {1'b0, head} + {1'b0, rd_idx};
      if (wr_sum >= (AW+1)'(DEPTH)) begin
         wr_sum = wr_sum - (AW+1)'(DEPTH);
      end
      if (rd_sum >= (AW+1)'(DEPTH)) begin
         rd_sum = rd_sum - (AW+1)'(DEPTH);
      end
      wr_addr = wr_sum[AW-1:0];
      rd_addr = rd_sum[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/sentence_chunk_segmenter.sv]
// Channel   Dir  Transfer                  Payload
// req_*     in   tvalid & tready           tdata[7:0] char_in, tuser[1:0] cmd
// rsp_*     out  tvalid & tready           tdata[7:0] char_out, tlast chunk_last,
//                                          tuser[0] from_flush
// csr_*     in   psel & penable & pwrite   min_chars at 0x0, max_chars at 0x4
//
// Each buffer character touched takes an address phase, then a data phase.
// A push scans from index min-1 to the end; each chunk found then takes a trim
// pass over the chunk, an emit pass and a skip of leading whitespace, all through
// the single read port. Reset clears length, head and the FSM and sets the limits
// to 1 and 64; the store needs no clearing.
// An rsp stall holds the emit pass; req is taken only when the FSM is idle.
`include "assert_macros.svh"

module sentence_chunk_segmenter #(
   parameter int BUFFER_DEPTH = scs_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // stream out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] char_out
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // [0] from_flush
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int LW = $clog2(BUFFER_DEPTH + 1);
   localparam logic [6:0] DEPTH7 = 7'(BUFFER_DEPTH);

   scs_pkg::state_type state_ff, state_in;
   logic          ph_ff, ph_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic [LW-1:0] len_ff, len_in;
   logic [AW-1:0] head_ff, head_in;
   logic [LW-1:0] bnd_ff, bnd_in;
   logic          flush_ff, flush_in;
   logic          prev_end_ff, prev_end_in;
   logic          sp_hit_ff, sp_hit_in;
   logic [LW-1:0] sp_pos_ff, sp_pos_in;
   logic          a_hit_ff, a_hit_in;
   logic [LW-1:0] a_ff, a_in;
   logic [LW-1:0] b_ff, b_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_flush_ff, rsp_flush_in;
   logic [6:0]    min_ff, max_ff;

   logic [6:0]    mn7, mx7;
   logic [LW-1:0] mn, mx;
   logic [7:0]    c;
   logic          wr_en;
   logic          out_free;
   logic          pe, sp, sp_hit_n;
   logic [LW-1:0] sp_pos_n;
   logic [LW-1:0] idx_inc;
   logic [AW:0]   head_sum;
   logic [AW:0]   head_one;
   logic          csr_wr;

   scs_ring #(.DEPTH(BUFFER_DEPTH)) u_ring (
      .clock   (clock),
      .head    (head_ff),
      .wr_en   (wr_en),
      .wr_idx  (len_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_idx  (idx_ff[AW-1:0]),
      .rd_data (c)
   );

   // effective limits
   always_comb begin
      mn7 = (min_ff == 7'd0) ? 7'd1 : min_ff;
      if (mn7 > DEPTH7) mn7 = DEPTH7;
      mx7 = (max_ff < mn7) ? mn7 : max_ff;
      if (mx7 > DEPTH7) mx7 = DEPTH7;
      mn = LW'(mn7);
      mx = LW'(mx7);
   end

   // register port
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == scs_pkg::REG_MAX) ? {25'd0, max_ff} : {25'd0, min_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 7'd1;
         max_ff <= 7'd64;
      end else if (csr_wr) begin
         if (csr_paddr[2] == scs_pkg::REG_MIN) min_ff <= csr_pwdata[6:0];
         else                                  max_ff <= csr_pwdata[6:0];
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign idx_inc   = LW'(idx_ff + 1'b1);
   assign head_sum  = {1'b0, head_ff} + (AW+1)'(bnd_ff);
   assign head_one  = {1'b0, head_ff} + (AW+1)'(1);
   assign req_tready = (state_ff == scs_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      head_in      = head_ff;
      bnd_in       = bnd_ff;
      flush_in     = flush_ff;
      prev_end_in  = prev_end_ff;
      sp_hit_in    = sp_hit_ff;
      sp_pos_in    = sp_pos_ff;
      a_hit_in     = a_hit_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_flush_in = rsp_flush_ff;
      wr_en        = 1'b0;
      pe           = scs_pkg::is_end(c);
      sp           = (c == scs_pkg::CH_SPACE) && (idx_ff >= mn) && (idx_ff < mx);
      sp_hit_n     = sp_hit_ff | sp;
      sp_pos_n     = sp ? idx_ff : sp_pos_ff;

      case (state_ff)
         scs_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               case (scs_pkg::cmd_type'(req_tuser))
                  scs_pkg::CMD_PUSH: begin
                     if (len_ff < LW'(BUFFER_DEPTH)) begin
                        wr_en  = 1'b1;
                        len_in = LW'(len_ff + 1'b1);
                     end
                     flush_in    = 1'b0;
                     state_in    = scs_pkg::ST_SCAN;
                     idx_in      = LW'(mn - 1'b1);
                     ph_in       = 1'b0;
                     prev_end_in = 1'b0;
                     sp_hit_in   = 1'b0;
                  end
                  scs_pkg::CMD_FLUSH: begin
                     bnd_in   = len_ff;
                     flush_in = 1'b1;
                     state_in = scs_pkg::ST_TRIM;
                     idx_in   = '0;
                     ph_in    = 1'b0;
                     a_hit_in = 1'b0;
                  end
                  scs_pkg::CMD_CLEAR: len_in = '0;
                  default: ;
               endcase
            end
         end
         scs_pkg::ST_SCAN: begin
            if (!ph_ff) begin
               if (len_ff < mn) state_in = scs_pkg::ST_IDLE;
               else             ph_in = 1'b1;
            end else if (prev_end_ff && scs_pkg::is_ws(c)) begin
               // sentence end followed by whitespace
               bnd_in   = idx_ff;
               state_in = scs_pkg::ST_TRIM;
               idx_in   = '0;
               ph_in    = 1'b0;
               a_hit_in = 1'b0;
            end else if (idx_inc == len_ff) begin
               idx_in   = '0;
               ph_in    = 1'b0;
               a_hit_in = 1'b0;
               if (pe) begin
                  bnd_in   = len_ff;
                  state_in = scs_pkg::ST_TRIM;
               end else if (len_ff >= mx) begin
                  // forced split: last space in [min, max-1], else max
                  bnd_in   = sp_hit_n ? sp_pos_n : mx;
                  state_in = scs_pkg::ST_TRIM;
               end else begin
                  state_in = scs_pkg::ST_IDLE;
               end
            end else begin
               prev_end_in = pe;
               sp_hit_in   = sp_hit_n;
               sp_pos_in   = sp_pos_n;
               idx_in      = idx_inc;
               ph_in       = 1'b0;
            end
         end
         scs_pkg::ST_TRIM: begin
            if (!ph_ff) begin
               if (idx_ff == bnd_ff) begin
                  if (a_hit_ff) begin
                     state_in = scs_pkg::ST_EMIT;
                     idx_in   = a_ff;
                  end else begin
                     state_in = scs_pkg::ST_DROP;
                  end
               end else begin
                  ph_in = 1'b1;
               end
            end else begin
               if (!scs_pkg::is_ws(c)) begin
                  if (!a_hit_ff) a_in = idx_ff;
                  a_hit_in = 1'b1;
                  b_in     = idx_inc;
               end
               idx_in = idx_inc;
               ph_in  = 1'b0;
            end
         end
         scs_pkg::ST_EMIT: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = c;
               rsp_last_in  = (idx_inc == b_ff);
               rsp_flush_in = flush_ff;
               if (idx_inc == b_ff) begin
                  state_in = scs_pkg::ST_DROP;
               end else begin
                  idx_in = idx_inc;
                  ph_in  = 1'b0;
               end
            end
         end
         scs_pkg::ST_DROP: begin
            if (flush_ff) begin
               len_in   = '0;
               flush_in = 1'b0;
               state_in = scs_pkg::ST_IDLE;
            end else begin
               head_in  = (head_sum >= (AW+1)'(BUFFER_DEPTH)) ?
                          AW'(head_sum - (AW+1)'(BUFFER_DEPTH)) : head_sum[AW-1:0];
               len_in   = LW'(len_ff - bnd_ff);
               idx_in   = '0;
               ph_in    = 1'b0;
               state_in = scs_pkg::ST_SKIP;
            end
         end
         scs_pkg::ST_SKIP: begin
            if (!ph_ff && len_ff != '0) begin
               ph_in = 1'b1;
            end else if (ph_ff && scs_pkg::is_ws(c)) begin
               head_in = (head_one >= (AW+1)'(BUFFER_DEPTH)) ?
                         AW'(head_one - (AW+1)'(BUFFER_DEPTH)) : head_one[AW-1:0];
               len_in  = LW'(len_ff - 1'b1);
               ph_in   = 1'b0;
            end else begin
               // remainder starts clean: rescan it
               state_in    = scs_pkg::ST_SCAN;
               idx_in      = LW'(mn - 1'b1);
               ph_in       = 1'b0;
               prev_end_in = 1'b0;
               sp_hit_in   = 1'b0;
            end
         end
         default: state_in = scs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scs_pkg::ST_IDLE;
         ph_ff        <= 1'b0;
         len_ff       <= '0;
         head_ff      <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         len_ff       <= len_in;
         head_ff      <= head_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      bnd_ff       <= bnd_in;
      prev_end_ff  <= prev_end_in;
      sp_hit_ff    <= sp_hit_in;
      sp_pos_ff    <= sp_pos_in;
      a_hit_ff     <= a_hit_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_flush_ff <= rsp_flush_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_flush_ff;

   `SCS_ASSERT(a_len_bound, len_ff <= LW'(BUFFER_DEPTH), "buffer length beyond depth")
   `SCS_ASSERT_IMPL(a_new_out, $rose(rsp_valid_ff), $past(state_ff) == scs_pkg::ST_EMIT, "transfer loaded outside emit")
   `SCS_ASSERT_IMPL(a_bnd_in_buf, state_ff == scs_pkg::ST_TRIM, bnd_ff <= len_ff, "chunk boundary past buffer end")
   `SCS_ASSERT_IMPL(a_emit_range, state_ff == scs_pkg::ST_EMIT, (idx_ff < b_ff) && (b_ff <= bnd_ff), "emit index outside trimmed chunk")

endmodule

[tb/sv/tb_sentence_chunk_segmenter.sv]
`timescale 1ns / 1ps

module tb_sentence_chunk_segmenter;

   // cmd code the block has no use for; it must be swallowed silently
   localparam logic [1:0] CMD_NOP = 2'd3;
   localparam int DEPTH = 64;
   // longest quiet stretch of a correct run is well under this
   localparam int WATCHDOG_LIMIT = 20000;
   // worst-case busy time of one item, with margin
   localparam int SETTLE_CYCLES = 600;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] ch;
   } seg_item_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       flush;
   } chunk_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] char_in
   logic [1:0]  req_tuser = '0;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] char_out
   logic        rsp_tlast;
   logic        rsp_tuser;        // [0] from_flush
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sentence_chunk_segmenter uut (.*);

   always #5 clock = ~clock;

   seg_item_type   pending_q[$];
   chunk_char_type chunk_chars_q[$];

   // shadow of the block: buffer, fill level and the two limit registers
   logic [7:0]  shadow_text[DEPTH];
   int unsigned shadow_len = 0;
   int unsigned min_reg = 1;
   int unsigned max_reg = 64;

   int  errors = 0;
   int  quiet_cycles = 0;
   bit  req_took = 0;
   bit  calm = 0;       // no idling on either side once set
   int  req_gap = 0;
   int  rsp_gap = 0;

   function automatic bit blank(logic [7:0] c);
      return (c >= 8'h09 && c <= 8'h0D) || c == scs_pkg::CH_SPACE || c == 8'h85 || c == 8'hA0;
   endfunction

   function automatic int unsigned lim_min();
      int unsigned m;
      m = min_reg;
      if (m < 1) m = 1;
      if (m > DEPTH) m = DEPTH;
      return m;
   endfunction

   function automatic int unsigned lim_max();
      int unsigned m;
      m = max_reg;
      if (m < lim_min()) m = lim_min();
      if (m > DEPTH) m = DEPTH;
      return m;
   endfunction

   // Chunk end in the shadow buffer, 0 if none yet.
   function automatic int unsigned split_point();
      int unsigned mn, mx, i;
      logic [7:0] c;
      mn = lim_min();
      mx = lim_max();
      if (shadow_len < mn) return 0;
      for (i = mn - 1; i < shadow_len; i++) begin
         c = shadow_text[i];
         if ((c == scs_pkg::CH_DOT || c == scs_pkg::CH_BANG || c == scs_pkg::CH_QUERY ||
              c == scs_pkg::CH_LF) &&
             (i + 1 == shadow_len || blank(shadow_text[i + 1])))
            return i + 1;
      end
      if (shadow_len < mx) return 0;
      // forced split: last space in [min, max-1] starts the remainder
      for (i = mx; i > mn; i--)
         if (shadow_text[i - 1] == scs_pkg::CH_SPACE) return i - 1;
      return mx;
   endfunction

   function automatic void queue_chunk(int unsigned n, logic fl);
      int unsigned a, b, i;
      chunk_char_type cc;
      a = 0;
      b = n;
      while (a < b && blank(shadow_text[a])) a++;
      while (b > a && blank(shadow_text[b - 1])) b--;
      for (i = a; i < b; i++) begin
         cc.ch = shadow_text[i];
         cc.last = (i + 1 == b);
         cc.flush = fl;
         chunk_chars_q.push_back(cc);
      end
   endfunction

   function automatic void drop_head(int unsigned k);
      int unsigned i;
      if (k > shadow_len) k = shadow_len;
      for (i = 0; i + k < shadow_len; i++) shadow_text[i] = shadow_text[i + k];
      shadow_len -= k;
   endfunction

   function automatic void segment(seg_item_type it);
      int unsigned cut;
      case (it.cmd)
         scs_pkg::CMD_PUSH: begin
            if (shadow_len < DEPTH) begin
               shadow_text[shadow_len] = it.ch;
               shadow_len++;
            end
            cut = split_point();
            while (cut > 0) begin
               queue_chunk(cut, 1'b0);
               drop_head(cut);
               while (shadow_len > 0 && blank(shadow_text[0])) drop_head(1);
               cut = split_point();
            end
         end
         scs_pkg::CMD_FLUSH: begin
            queue_chunk(shadow_len, 1'b1);
            shadow_len = 0;
         end
         scs_pkg::CMD_CLEAR: shadow_len = 0;
         default: ;
      endcase
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
   endtask

   // ---------------------------------------------------------------
   // Driver: req side changes on the falling edge, pulled from pending_q.
   // A transfer seen at the previous rising edge frees the slot.
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      seg_item_type it;
      bit nv;
      if (!reset) begin
         nv = req_tvalid && !req_took;
         if (!nv) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_q.size() > 0) begin
               it = pending_q.pop_front();
               req_tdata <= it.ch;
               req_tuser <= it.cmd;
               nv = 1;
               if (!calm && $urandom_range(3) == 0) req_gap = $urandom_range(1, 12);
            end
         end
         req_tvalid <= nv;
         req_took = 0;
         // rsp stalls in bursts
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(7) == 0) rsp_gap = $urandom_range(1, 12);
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: both transfers sampled on the rising edge; each accepted
   // req item is run through the shadow model, each rsp transfer is
   // checked against the oldest predicted character.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      seg_item_type it;
      chunk_char_type want;
      if (!reset) begin
         quiet_cycles++;
         if (req_tvalid && req_tready) begin
            it.cmd = req_tuser;
            it.ch = req_tdata;
            segment(it);
            req_took = 1;
            quiet_cycles = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles = 0;
            if (chunk_chars_q.size() == 0) begin
               report("unexpected transfer", rsp_tdata, 0);
            end else begin
               want = chunk_chars_q.pop_front();
               if (rsp_tdata !== want.ch) report("char_out", rsp_tdata, want.ch);
               if (rsp_tlast !== want.last) report("chunk_last", rsp_tlast, want.last);
               if (rsp_tuser !== want.flush) report("from_flush", rsp_tuser, want.flush);
            end
         end
         if (csr_psel && csr_penable) quiet_cycles = 0;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic add(logic [1:0] cmd, logic [7:0] ch);
      seg_item_type it;
      it.cmd = cmd;
      it.ch = ch;
      pending_q.push_back(it);
   endtask

   task automatic add_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) add(scs_pkg::CMD_PUSH, s[i]);
   endtask

   // One word of plain letters, now and then a high Latin-1 byte.
   task automatic add_word();
      int n, i;
      n = $urandom_range(1, 9);
      for (i = 0; i < n; i++)
         if ($urandom_range(9) == 0) add(scs_pkg::CMD_PUSH, 8'($urandom_range(8'hC0, 8'hFF)));
         else add(scs_pkg::CMD_PUSH, 8'($urandom_range("a", "z")));
   endtask

   task automatic add_sentence();
      int n, i;
      logic [7:0] enders[4];
      logic [7:0] seps[6];
      enders = '{scs_pkg::CH_DOT, scs_pkg::CH_BANG, scs_pkg::CH_QUERY, scs_pkg::CH_LF};
      seps = '{scs_pkg::CH_SPACE, scs_pkg::CH_SPACE, scs_pkg::CH_SPACE, 8'h09, 8'h85, 8'hA0};
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
         add_word();
         if (i + 1 < n) add(scs_pkg::CMD_PUSH, seps[$urandom_range(5)]);
      end
      // some run-ons with no sentence end, to force splits
      if ($urandom_range(4) != 0) begin
         add(scs_pkg::CMD_PUSH, enders[$urandom_range(3)]);
         if ($urandom_range(3) == 0) add(scs_pkg::CMD_PUSH, enders[$urandom_range(3)]);
      end
      add(scs_pkg::CMD_PUSH, seps[$urandom_range(5)]);
   endtask

   task automatic add_noise();
      case ($urandom_range(5))
         0: add(scs_pkg::CMD_FLUSH, 8'($urandom));
         1: add(scs_pkg::CMD_CLEAR, 8'($urandom));
         2: add(CMD_NOP, 8'($urandom));
         default: add(scs_pkg::CMD_PUSH, 8'($urandom));
      endcase
   endtask

   task automatic add_random(int n);
      int start;
      start = pending_q.size();
      while (pending_q.size() - start < n)
         if ($urandom_range(9) < 7) add_sentence();
         else add_noise();
      if ($urandom_range(1) == 0) add(scs_pkg::CMD_FLUSH, 8'h00);
   endtask

   // Everything sent and drained, then time for a last no-output item.
   task automatic settle();
      while (pending_q.size() > 0 || req_tvalid || chunk_chars_q.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic reg_sel, int unsigned value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (reg_sel == scs_pkg::REG_MIN) min_reg = value & 32'h7F;
      else max_reg = value & 32'h7F;
   endtask

   task automatic set_limits(int unsigned mn, int unsigned mx);
      settle();
      csr_write(scs_pkg::REG_MIN, mn);
      csr_write(scs_pkg::REG_MAX, mx);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset limits (1, 64)
      add_text("A. b!?c");
      add(scs_pkg::CMD_PUSH, scs_pkg::CH_LF);
      add(scs_pkg::CMD_PUSH, 8'hA0);        // non-breaking space trimmed
      add(scs_pkg::CMD_PUSH, 8'h85);
      add(scs_pkg::CMD_PUSH, 8'h09);
      add(scs_pkg::CMD_PUSH, 8'hFF);
      add(scs_pkg::CMD_PUSH, 8'h00);
      add(scs_pkg::CMD_FLUSH, 8'hFF);
      add(scs_pkg::CMD_PUSH, scs_pkg::CH_SPACE);
      add(scs_pkg::CMD_FLUSH, 8'h00);       // all-blank flush: nothing out
      add(scs_pkg::CMD_FLUSH, 8'h00);       // empty flush
      add_text("xy");
      add(scs_pkg::CMD_CLEAR, 8'h55);
      add(CMD_NOP, 8'hAA);
      add(scs_pkg::CMD_PUSH, 8'h7F);
      add(scs_pkg::CMD_FLUSH, 8'h00);
      add_random(25);

      // zero min acts as 1, zero max follows min: one char per chunk
      set_limits(0, 0);
      add_random(25);
      // max below min
      set_limits(10, 3);
      add_random(30);
      // everything past the depth saturates; buffer fills to 64
      set_limits(127, 127);
      add_random(35);
      set_limits(64, 64);
      add_random(25);
      // typical: short forced splits at spaces
      set_limits(5, 12);
      add_random(25);

      // last stretch with no idling
      settle();
      calm = 1;
      add_random(20);
      settle();

      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
